// ----- src/dgps_pkg.sv -----
// Package for the dual-grain pitch shifter: sequencer states, control
// structs, shared arithmetic widths and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dgps_pkg;

  // Shared multiplier operand and accumulator widths
  localparam int A_W   = 42;
  localparam int B_W   = 22;
  localparam int ACC_W = A_W + B_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WET     = 4'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_P2,
    ST_IDX1_LD,
    ST_IDX1,
    ST_IDX2_LD,
    ST_IDX2,
    ST_RD,
    ST_CALC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic en;
    logic accum;
  } mac_ctl_t;

  typedef struct packed {
    logic start;
    logic run;
    logic idx_mode;
  } div_ctl_t;

endpackage
`default_nettype wire

// ----- src/dgps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dgps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- src/dgps_window.sv -----
// Hann window ROM, sin^2(pi*k/N) in Q1.16, built at elaboration from a
// fixed-point sine series. Registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dgps_window #(
  parameter int WINDOW_ENTRIES = 1024
) (
  input  logic                              clk,
  input  logic [$clog2(WINDOW_ENTRIES)-1:0] addr,
  output logic [16:0]                       data
);

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  function automatic logic [16:0] hann_entry(input int unsigned k);
    logic [63:0]        a;
    logic [63:0]        th;
    logic [63:0]        th2;
    logic [63:0]        term;
    logic [63:0]        s;
    logic [63:0]        w;
    logic signed [63:0] sum;
    int                 j;
    a = 64'(k);
    if (a > 64'(WINDOW_ENTRIES) - a) begin
      a = 64'(WINDOW_ENTRIES) - a;
    end
    th   = PI_Q30 * a / WINDOW_ENTRIES;
    th2  = (th * th) >> 30;
    sum  = $signed(th);
    term = th;
    for (j = 1; j <= 6; j++) begin
      term = (term * th2) >> 30;
      // series term divided by (2j)(2j+1)
      case (j)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if (j[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    s = $unsigned(sum);
    w = (s * s + (64'd1 << 43)) >> 44;
    if (w > 64'd65536) begin
      w = 64'd65536;
    end
    return 17'(w);
  endfunction

  logic [16:0] rom [WINDOW_ENTRIES];
  logic [16:0] data_r;

  // Constant table contents
  for (genvar k = 0; k < WINDOW_ENTRIES; k++) begin : g_rom
    assign rom[k] = hann_entry(k);
  end

  always_ff @(posedge clk) begin
    data_r <= rom[addr];
  end

  assign data = data_r;

endmodule
`default_nettype wire

// ----- src/dgps_div.sv -----
// Shared restoring divider: one compare and subtract per cycle. Serves the
// phase modulo and the window index divisions. Depends on dgps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dgps_div #(
  parameter int PW = 31,
  parameter int WB = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dgps_pkg::div_ctl_t       ctl,
  input  logic [PW+WB-1:0]         num,
  input  logic [PW-1:0]            den,
  output logic [PW+WB-1:0]         rem,
  output logic [WB-1:0]            quot,
  output logic                     last
);
  import dgps_pkg::*;

  localparam int DW   = PW + WB;
  localparam int NQ   = PW - 22;
  localparam int KMAX = (NQ > WB) ? NQ : WB;
  localparam int KW   = $clog2(KMAX);
  localparam int SW   = PW + KMAX;

  logic [KW-1:0]   k_r;
  logic [DW-1:0]   rem_r;
  logic [KMAX-1:0] quot_r;
  logic [SW-1:0]   den_sh;
  logic [SW-1:0]   rem_x;
  logic            ge;

  // Divisor aligned to the current quotient bit
  assign den_sh = SW'(den) << k_r;
  assign rem_x  = SW'(rem_r);
  assign ge     = (rem_x >= den_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (ctl.start) begin
      k_r <= ctl.idx_mode ? KW'(WB - 1) : KW'(NQ - 1);
    end else if (ctl.run) begin
      k_r <= k_r - KW'(1);
    end
  end

  // One quotient bit per cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r  <= num;
      quot_r <= '0;
    end else if (ctl.run && ge) begin
      rem_r       <= DW'(rem_x - den_sh);
      quot_r[k_r] <= 1'b1;
    end
  end

  assign rem  = rem_r;
  assign quot = quot_r[WB-1:0];
  assign last = ctl.run && (k_r == '0);

endmodule
`default_nettype wire

// ----- src/dgps_mac.sv -----
// Shared signed multiply-accumulate unit with a registered accumulator.
// Depends on dgps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dgps_mac (
  input  logic                                 clk,
  input  dgps_pkg::mac_ctl_t                   ctl,
  input  logic signed [dgps_pkg::A_W-1:0]      op_a,
  input  logic signed [dgps_pkg::B_W-1:0]      op_b,
  output logic signed [dgps_pkg::ACC_W-1:0]    acc
);
  import dgps_pkg::*;

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_r;

  assign prod = op_a * op_b;

  // Start a new sum or add to the running one
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= (ctl.accum ? acc_r : '0) + prod;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

// ----- src/dual_grain_pitch_shifter_core.sv -----
// Top level of the dual-grain pitch shifter: sequencer, registers and the
// history RAM. Depends on dgps_pkg, dgps_ram, dgps_window, dgps_div, dgps_mac.
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  in_tdata  {in_right, in_left}
//  out_     master     out_tvalid/out_tready out_tdata {out_right, out_left}
//  cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each stereo pair runs through the shared one-bit-per-cycle divider,
// (PW-22) + 2*WB = 29 steps (phase modulo, two window indexes), and the
// shared multiplier (16 products, 4 more on respawn), so a pair that
// respawns the grain takes longer; out_tvalid rises as the result enters
// the output register. in_tready is high only while idle. A finished pair
// waits in the output register; the next pair is taken meanwhile and holds
// in its last state until that register frees. Reset clears control only;
// the history reads as zero until written, tracked by the write pointer
// and a wrap flag.
`timescale 1ns / 1ps
`default_nettype none
module dual_grain_pitch_shifter_core #(
  parameter int BUF_DEPTH      = 32768,
  parameter int WINDOW_ENTRIES = 1024,
  parameter int SAMPLE_BITS    = 24
) (
  input  logic clk,
  input  logic rst_n,
  // input pair
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,   // in_left, in_right
  // result pair
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     out_tdata,  // out_left, out_right
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dgps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [17:0]                            cfg_data
);
  import dgps_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int SB2  = SB + 2;
  localparam int TD_W = ((2*SB+7)/8)*8;
  localparam int AW   = $clog2(BUF_DEPTH);
  localparam int PW   = AW + 16;
  localparam int PW1  = PW + 1;
  localparam int WB   = $clog2(WINDOW_ENTRIES);
  localparam int DW   = PW + WB;

  localparam logic [PW:0]     BUFQ       = PW1'(BUF_DEPTH) << 16;
  localparam logic [AW-1:0]   LAST_ADDR  = AW'(BUF_DEPTH - 1);
  localparam logic [16:0]     LEN_MAX    = 17'(BUF_DEPTH - 4);
  localparam logic [16:0]     LEN_MIN    = 17'd64;
  localparam logic [16:0]     UNITY      = 17'd65536;
  localparam logic [31:0]     LCG_MUL    = 32'd1664525;
  localparam logic [31:0]     LCG_ADD    = 32'd1013904223;
  localparam logic [31:0]     SEED_RESET = 32'h12345678;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) << (SB - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  function automatic logic [SB-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v;
    if (t > SMAX) begin
      t = SMAX;
    end
    if (t < SMIN) begin
      t = SMIN;
    end
    return SB'(t);
  endfunction

  // Control and state
  state_t        state_r, state_nxt;
  logic [4:0]    step_r, step_nxt;
  logic [17:0]   pitch_r;
  logic [14:0]   glen_r;
  logic [15:0]   dens_r;
  logic [16:0]   wet_r;
  logic [PW-1:0] phase_r;
  logic [31:0]   seed_r;
  logic [AW-1:0] wp_r;
  logic          wrap_r;
  logic          out_valid_r;

  // Payload
  logic signed [SB-1:0]  dl_r, dr_r;
  logic [PW-1:0]         p2_r;
  logic [WB-1:0]         idx1_r;
  logic [2*SB-1:0]       wd0_r, wd1_r, wd2_r, wd3_r;
  logic                  vld_r;
  logic [15:0]           fr1_r, fr2_r;
  logic [16:0]           win1_r, win2_r;
  logic signed [SB-1:0]  gl1_r, gr1_r, gl2_r, gr2_r;
  logic signed [SB2-1:0] wl_r, wr_r;
  logic [SB-1:0]         resl_r, resr_r;
  logic [2*SB-1:0]       out_data_r;

  logic in_acc, load_out;

  // Clamped settings
  logic [16:0]   glen_x;
  logic [AW-1:0] len_c;
  logic [PW-1:0] lq;
  logic [16:0]   m_c, om_c;

  assign glen_x = 17'(glen_r);
  assign len_c  = (glen_x < LEN_MIN) ? AW'(LEN_MIN) :
                  (glen_x > LEN_MAX) ? AW'(LEN_MAX) : AW'(glen_x);
  assign lq     = {len_c, 16'b0};
  assign m_c    = (wet_r > UNITY) ? UNITY : wet_r;
  assign om_c   = UNITY - m_c;

  // Shared units
  div_ctl_t                div_ctl;
  logic [DW-1:0]           div_num, div_rem;
  logic [WB-1:0]           div_quot;
  logic                    div_last;
  mac_ctl_t                mac_ctl;
  logic signed [A_W-1:0]   mac_a;
  logic signed [B_W-1:0]   mac_b;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd_c;

  assign rnd_c = (acc + RND_HALF) >>> 16;

  dgps_div #(.PW(PW), .WB(WB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (lq),
    .rem   (div_rem),
    .quot  (div_quot),
    .last  (div_last)
  );

  dgps_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  // Window ROM: first index, then the second straight from the divider
  logic [WB-1:0] win_addr;
  logic [16:0]   win_data;

  assign win_addr = (state_r == ST_RD && step_r == 5'd0) ? idx1_r : div_quot;

  dgps_window #(.WINDOW_ENTRIES(WINDOW_ENTRIES)) u_window (
    .clk  (clk),
    .addr (win_addr),
    .data (win_data)
  );

  // History read address for grain one (steps 0,1) or grain two (2,3)
  logic [PW-1:0] p_sel;
  logic [PW:0]   diff_c, posq_c;
  logic [AW-1:0] ia0, ia1, raddr;
  logic          rvalid_c, re;
  logic [2*SB-1:0] rdata;

  assign p_sel    = step_r[1] ? p2_r : phase_r;
  assign diff_c   = {1'b0, wp_r, 16'b0} - {1'b0, p_sel};
  assign posq_c   = diff_c[PW] ? diff_c + BUFQ : diff_c;
  assign ia0      = posq_c[PW-1:16];
  assign ia1      = (ia0 == LAST_ADDR) ? '0 : ia0 + AW'(1);
  assign raddr    = step_r[0] ? ia1 : ia0;
  assign rvalid_c = wrap_r || (raddr <= wp_r);
  assign re       = (state_r == ST_RD) && (step_r < 5'd4);

  dgps_ram #(.WIDTH(2*SB), .DEPTH(BUF_DEPTH)) u_hist (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp_r),
    .wdata (in_tdata[2*SB-1:0]),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Second grain phase and next phase
  logic [PW:0]   p2_sum, np_c;
  logic [PW-1:0] p2_c;
  logic          respawn;
  logic [32:0]   resp_c;

  assign p2_sum  = {1'b0, div_rem[PW-1:0]} + {2'b0, len_c, 15'b0};
  assign p2_c    = (p2_sum >= {1'b0, lq}) ? PW'(p2_sum - {1'b0, lq}) : PW'(p2_sum);
  assign np_c    = {1'b0, phase_r} + PW1'(pitch_r);
  assign respawn = (np_c >= {1'b0, lq});
  assign resp_c  = {1'b0, acc[55:24]};

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Sequencer: next state and unit controls
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    div_ctl   = '0;
    div_num   = acc[DW-1:0];
    case (state_r)
      ST_IDLE: begin
        div_num = DW'(phase_r);
        if (in_acc) begin
          div_ctl.start = 1'b1;
          state_nxt     = ST_MOD;
        end
      end
      ST_MOD: begin
        div_ctl.run = 1'b1;
        if (div_last) begin
          state_nxt = ST_P2;
        end
      end
      ST_P2: state_nxt = ST_IDX1_LD;
      ST_IDX1_LD: begin
        div_ctl.start    = 1'b1;
        div_ctl.idx_mode = 1'b1;
        state_nxt        = ST_IDX1;
      end
      ST_IDX1: begin
        div_ctl.run = 1'b1;
        if (div_last) begin
          state_nxt = ST_IDX2_LD;
        end
      end
      ST_IDX2_LD: begin
        div_ctl.start    = 1'b1;
        div_ctl.idx_mode = 1'b1;
        state_nxt        = ST_IDX2;
      end
      ST_IDX2: begin
        div_ctl.run = 1'b1;
        if (div_last) begin
          state_nxt = ST_RD;
          step_nxt  = '0;
        end
      end
      ST_RD: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd4) begin
          state_nxt = ST_CALC;
          step_nxt  = '0;
        end
      end
      ST_CALC: begin
        step_nxt = step_r + 5'd1;
        if ((step_r == 5'd16 && !respawn) || step_r == 5'd20) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier operand selection
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    case (state_r)
      ST_P2: begin
        mac_ctl.en = 1'b1;
        mac_a      = A_W'(div_rem[PW-1:0]);
        mac_b      = B_W'(WINDOW_ENTRIES);
      end
      ST_IDX1_LD: begin
        mac_ctl.en = 1'b1;
        mac_a      = A_W'(p2_r);
        mac_b      = B_W'(WINDOW_ENTRIES);
      end
      ST_CALC: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = step_r[0];
        case (step_r)
          5'd0: begin
            mac_a = A_W'($signed(wd0_r[SB-1:0]));
            mac_b = B_W'(UNITY - {1'b0, fr1_r});
          end
          5'd1: begin
            mac_a = A_W'($signed(wd1_r[SB-1:0]));
            mac_b = B_W'(fr1_r);
          end
          5'd2: begin
            mac_a = A_W'($signed(wd0_r[2*SB-1:SB]));
            mac_b = B_W'(UNITY - {1'b0, fr1_r});
          end
          5'd3: begin
            mac_a = A_W'($signed(wd1_r[2*SB-1:SB]));
            mac_b = B_W'(fr1_r);
          end
          5'd4: begin
            mac_a = A_W'($signed(wd2_r[SB-1:0]));
            mac_b = B_W'(UNITY - {1'b0, fr2_r});
          end
          5'd5: begin
            mac_a = A_W'($signed(wd3_r[SB-1:0]));
            mac_b = B_W'(fr2_r);
          end
          5'd6: begin
            mac_a = A_W'($signed(wd2_r[2*SB-1:SB]));
            mac_b = B_W'(UNITY - {1'b0, fr2_r});
          end
          5'd7: begin
            mac_a = A_W'($signed(wd3_r[2*SB-1:SB]));
            mac_b = B_W'(fr2_r);
          end
          5'd8: begin
            mac_a = A_W'(gl1_r);
            mac_b = B_W'(win1_r);
          end
          5'd9: begin
            mac_a = A_W'(gl2_r);
            mac_b = B_W'(win2_r);
          end
          5'd10: begin
            mac_a = A_W'(gr1_r);
            mac_b = B_W'(win1_r);
          end
          5'd11: begin
            mac_a = A_W'(gr2_r);
            mac_b = B_W'(win2_r);
          end
          5'd12: begin
            mac_a = A_W'(dl_r);
            mac_b = B_W'(om_c);
          end
          5'd13: begin
            mac_a = A_W'(wl_r);
            mac_b = B_W'(m_c);
          end
          5'd14: begin
            mac_a = A_W'(dr_r);
            mac_b = B_W'(om_c);
          end
          5'd15: begin
            mac_a = A_W'(wr_r);
            mac_b = B_W'(m_c);
          end
          5'd16: begin
            // seed times multiplier, only when the grain respawns
            mac_ctl.en    = respawn;
            mac_ctl.accum = 1'b0;
            mac_a         = A_W'(seed_r);
            mac_b         = B_W'(LCG_MUL);
          end
          5'd17: begin
            mac_a = A_W'(LCG_ADD);
            mac_b = B_W'(1);
          end
          5'd18: begin
            mac_ctl.accum = 1'b0;
            mac_a         = A_W'(acc[23:0]);
            mac_b         = B_W'(dens_r);
          end
          5'd19: begin
            mac_ctl.accum = 1'b0;
            mac_a         = A_W'(acc[39:0]);
            mac_b         = B_W'(len_c);
          end
          default: mac_ctl.en = 1'b0;
        endcase
      end
      default: mac_ctl = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      pitch_r     <= 18'd65536;
      glen_r      <= 15'd2880;
      dens_r      <= 16'd39322;
      wet_r       <= 17'd32768;
      phase_r     <= '0;
      seed_r      <= SEED_RESET;
      wp_r        <= '0;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      // configuration transfer
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PITCH:   pitch_r <= cfg_data;
          CFG_LENGTH:  glen_r  <= cfg_data[14:0];
          CFG_DENSITY: dens_r  <= cfg_data[15:0];
          CFG_WET:     wet_r   <= cfg_data[16:0];
          default:     ;
        endcase
      end
      // phase advance, or respawn from the new seed
      if (state_r == ST_CALC && step_r == 5'd16 && !respawn) begin
        phase_r <= PW'(np_c);
      end
      if (state_r == ST_CALC && step_r == 5'd18) begin
        seed_r <= acc[31:0];
      end
      if (state_r == ST_CALC && step_r == 5'd20) begin
        phase_r <= (resp_c >= 33'(lq)) ? '0 : PW'(resp_c);
      end
      // advance write pointer as the result leaves
      if (load_out) begin
        wp_r <= (wp_r == LAST_ADDR) ? '0 : wp_r + AW'(1);
        if (wp_r == LAST_ADDR) begin
          wrap_r <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dl_r <= $signed(in_tdata[SB-1:0]);
      dr_r <= $signed(in_tdata[2*SB-1:SB]);
    end
    if (state_r == ST_P2) begin
      p2_r <= p2_c;
    end
    if (state_r == ST_IDX2_LD) begin
      idx1_r <= div_quot;
    end
    if (state_r == ST_RD) begin
      vld_r <= rvalid_c;
      case (step_r)
        5'd0: begin
          fr1_r <= posq_c[15:0];
        end
        5'd1: begin
          wd0_r  <= vld_r ? rdata : '0;
          win1_r <= win_data;
        end
        5'd2: begin
          wd1_r  <= vld_r ? rdata : '0;
          win2_r <= win_data;
          fr2_r  <= posq_c[15:0];
        end
        5'd3: wd2_r <= vld_r ? rdata : '0;
        5'd4: wd3_r <= vld_r ? rdata : '0;
        default: ;
      endcase
    end
    if (state_r == ST_CALC) begin
      case (step_r)
        5'd2:  gl1_r  <= SB'(rnd_c);
        5'd4:  gr1_r  <= SB'(rnd_c);
        5'd6:  gl2_r  <= SB'(rnd_c);
        5'd8:  gr2_r  <= SB'(rnd_c);
        5'd10: wl_r   <= SB2'(rnd_c);
        5'd12: wr_r   <= SB2'(rnd_c);
        5'd14: resl_r <= sat(rnd_c);
        5'd16: resr_r <= sat(rnd_c);
        default: ;
      endcase
    end
    if (load_out) begin
      out_data_r <= {resr_r, resl_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TD_W'(out_data_r);

endmodule
`default_nettype wire

// ----- tb/dual_grain_pitch_shifter_core_test.sv -----
// Testbench for the dual-grain pitch shifter core: drives stereo pairs and
// register writes, predicts every result pair and checks it in order.
// Depends on dgps_pkg and the dual_grain_pitch_shifter_core RTL.
`timescale 1ns / 1ps
module dual_grain_pitch_shifter_core_test;
  import dgps_pkg::*;

  localparam int HIST_DEPTH = 32768;
  localparam int WIN_SIZE   = 1024;
  localparam int SETTLE     = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX = 4'd15;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;     // in_left, in_right
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;         // out_left, out_right
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;

  // Predictor state and register copies
  logic signed [23:0] hist_l [HIST_DEPTH];
  logic signed [23:0] hist_r [HIST_DEPTH];
  longint unsigned hann_lut [WIN_SIZE];
  int unsigned wr_pos;
  longint unsigned grain_ph;
  logic [31:0] lcg_seed;
  logic [17:0] pitch_q;
  logic [14:0] length_q;
  logic [15:0] density_q;
  logic [16:0] wet_q;

  pair_t expected_pairs [$];
  int errors = 0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  int hold_count = 0;
  int stall_left = 0;
  int in_gap;

  dual_grain_pitch_shifter_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hann entry by a Taylor series of sin in Q30, squared into Q1.16
  function automatic longint unsigned hann_value(longint unsigned k);
    longint unsigned a, th, th2, term, s, w;
    longint sum;
    a = k;
    if (a > WIN_SIZE - a) a = WIN_SIZE - a;
    th = 64'd3373259426 * a / WIN_SIZE;
    th2 = (th * th) >> 30;
    sum = longint'(th);
    term = th;
    for (int j = 1; j <= 6; j++) begin
      term = ((term * th2) >> 30) / ((2 * j) * (2 * j + 1));
      if (j & 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    s = longint'(sum);
    w = (s * s + (64'd1 << 43)) >> 44;
    if (w > 65536) w = 65536;
    return w;
  endfunction

  function automatic longint round16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // Interpolated read at a phase behind the write pointer
  task automatic read_grain(input longint unsigned ph, output longint gl, output longint gr);
    longint unsigned bufq, posq;
    int unsigned i0, i1;
    longint fr;
    bufq = longint'(HIST_DEPTH) << 16;
    posq = ((longint'(wr_pos) << 16) + bufq - (ph % bufq)) % bufq;
    i0 = 32'(posq >> 16);
    i1 = (i0 + 1) % HIST_DEPTH;
    fr = posq & 16'hFFFF;
    gl = round16(longint'(hist_l[i0]) * (65536 - fr) + longint'(hist_l[i1]) * fr);
    gr = round16(longint'(hist_r[i0]) * (65536 - fr) + longint'(hist_r[i1]) * fr);
  endtask

  // Compute the output pair for one accepted input pair and advance state
  task automatic shift_pair(input logic signed [23:0] dl, input logic signed [23:0] dr);
    longint unsigned len, lq, p1, p2, idx1, idx2, rv, resp;
    longint gl1, gr1, gl2, gr2, w1, w2, wl, wr, m;
    pair_t res;
    len = length_q;
    if (len < 64) len = 64;
    if (len > HIST_DEPTH - 4) len = HIST_DEPTH - 4;
    lq = len << 16;
    m = (wet_q > 65536) ? 65536 : wet_q;
    hist_l[wr_pos] = dl;
    hist_r[wr_pos] = dr;
    p1 = grain_ph;
    p2 = (p1 + (len << 15)) % lq;
    read_grain(p1, gl1, gr1);
    read_grain(p2, gl2, gr2);
    idx1 = ((p1 % lq) * WIN_SIZE) / lq;
    idx2 = (p2 * WIN_SIZE) / lq;
    w1 = hann_lut[idx1 % WIN_SIZE];
    w2 = hann_lut[idx2 % WIN_SIZE];
    wl = round16(gl1 * w1 + gl2 * w2);
    wr = round16(gr1 * w1 + gr2 * w2);
    res.left = clamp24(round16(longint'(dl) * (65536 - m) + wl * m));
    res.right = clamp24(round16(longint'(dr) * (65536 - m) + wr * m));
    expected_pairs.push_back(res);
    grain_ph = p1 + pitch_q;
    if (grain_ph >= lq) begin
      lcg_seed = 32'd1664525 * lcg_seed + 32'd1013904223;
      rv = lcg_seed & 32'h00FFFFFF;
      resp = (rv * density_q * len) >> 24;
      grain_ph = (resp >= lq) ? 0 : resp;
    end
    wr_pos = (wr_pos + 1) % HIST_DEPTH;
  endtask

  // Offer one pair, hold until the transfer, then maybe idle
  task automatic send_pair(input logic signed [23:0] l, input logic signed [23:0] r);
    in_tdata <= {r, l};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    shift_pair(l, r);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      in_gap = $urandom_range(1, 10);
      repeat (in_gap) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Let the block drain before a register write
  task automatic wait_idle();
    stop_sending();
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [17:0] val);
    wait_idle();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PITCH:   pitch_q = val;
      CFG_LENGTH:  length_q = val[14:0];
      CFG_DENSITY: density_q = val[15:0];
      CFG_WET:     wet_q = val[16:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($urandom_range(0, 255) - 128);
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_pair(rand_sample(), rand_sample());
  endtask

  task automatic report_mismatch(input string what, input logic signed [23:0] got,
                                 input logic signed [23:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[23:0], 24'sd0);
      end else begin
        want = expected_pairs.pop_front();
        if (out_tdata[23:0] !== want.left) report_mismatch("left", out_tdata[23:0], want.left);
        if (out_tdata[47:24] !== want.right)
          report_mismatch("right", out_tdata[47:24], want.right);
      end
    end
  end

  // Receiver: long hold-off on request, else random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      if (hold_count == 399) begin
        hold_req <= 1'b0;
        hold_count <= 0;
      end else begin
        hold_count <= hold_count + 1;
      end
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic test_extremes();
    send_pair(24'sh7FFFFF, 24'sh800000);
    send_pair(24'sh800000, 24'sh7FFFFF);
    send_pair(24'sh7FFFFF, 24'sh7FFFFF);
    send_pair(24'sh800000, 24'sh800000);
    send_pair(24'sh000000, 24'sh000000);
    send_pair(-24'sd1, 24'sd1);
    send_random(6);
  endtask

  task automatic test_register_edges();
    write_reg(CFG_WET, 18'd131071);       // above full counts as fully wet
    send_random(4);
    write_reg(CFG_WET, 18'd0);
    send_random(3);
    write_reg(CFG_PITCH, 18'd0);          // frozen phase
    write_reg(CFG_WET, 18'd65536);
    send_random(4);
    write_reg(CFG_UNUSED, 18'h3FFFF);     // write to an unused index is dropped
    write_reg(CFG_TOP_IDX, 18'd5);
    send_random(2);
  endtask

  task automatic test_respawn();
    write_reg(CFG_PITCH, 18'd131072);
    write_reg(CFG_LENGTH, 18'd0);         // short grain clamps to 64
    write_reg(CFG_DENSITY, 18'd65535);
    send_random(70);
    write_reg(CFG_DENSITY, 18'd0);
    send_random(40);
    write_reg(CFG_LENGTH, 18'd32767);     // long grain clamps to depth minus four
    write_reg(CFG_PITCH, 18'd262143);
    send_random(40);
  endtask

  task automatic test_phase_past_grain();
    write_reg(CFG_PITCH, 18'd131072);
    write_reg(CFG_LENGTH, 18'd3000);
    write_reg(CFG_DENSITY, 18'd39322);
    send_random(60);
    write_reg(CFG_LENGTH, 18'd64);        // lower length with the phase far beyond it
    send_random(10);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_PITCH, 18'd98304);
    write_reg(CFG_LENGTH, 18'd500);
    @(posedge clk);
    hold_req = 1'b1;
    send_random(30);
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(CFG_PITCH, (p % 3 == 0) ? 18'd32768 : 18'($urandom_range(32768, 131072)));
      write_reg(CFG_LENGTH, (p % 4 == 1) ? 18'd64 : 18'($urandom_range(64, 4000)));
      write_reg(CFG_DENSITY, (p % 3 == 2) ? 18'd65535 : 18'($urandom_range(0, 65535)));
      write_reg(CFG_WET, (p % 5 == 0) ? 18'd65536 : 18'($urandom_range(0, 65536)));
      send_random(per_phase);
    end
  endtask

  initial begin
    for (int k = 0; k < HIST_DEPTH; k++) begin
      hist_l[k] = '0;
      hist_r[k] = '0;
    end
    for (int k = 0; k < WIN_SIZE; k++) hann_lut[k] = hann_value(k);
    wr_pos = 0;
    grain_ph = 0;
    lcg_seed = 32'h12345678;
    pitch_q = 18'd65536;
    length_q = 15'd2880;
    density_q = 16'd39322;
    wet_q = 17'd32768;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_register_edges();
    test_respawn();
    test_phase_past_grain();
    test_backpressure();
    test_random_settings(6, 100);
    idle_en = 1'b0;
    test_random_settings(1, 100);

    wait_idle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
